/* src/tlv_string_part_parser_core_assert.svh */
// Assertion macros used by the TLV string chunk parser checker.
`ifndef TLV_STRING_PART_PARSER_CORE_ASSERT_SVH
`define TLV_STRING_PART_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TLVSPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TLVSPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tlvspp_pkg.sv */
// Package for the TLV string chunk parser: types, status codes and constants.
`default_nettype none

package tlvspp_pkg;

    // Header is a 2-byte type plus a 2-byte big-endian length
    localparam int unsigned HEADER_BYTES = 2 * 2;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned STAT_W = 3;

    localparam logic [LEN_W-1:0] CAP_RESET = 16'd64;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BUF_SHORT = 3'd1;
    localparam t_status ST_TOO_BIG   = 3'd2;
    localparam t_status ST_HDR_SHORT = 3'd3;
    localparam t_status ST_OUT_SMALL = 3'd4;
    localparam t_status ST_NO_NUL    = 3'd5;

    // Header byte positions within the chunk
    localparam logic [1:0] HC_LEN_HI = 2'd2;
    localparam logic [1:0] HC_LEN_LO = 2'd3;

endpackage

`default_nettype wire

/* src/tlv_string_part_parser_core.sv */
// Top level of the TLV string chunk parser: header checks and payload pass-through.
//
// Usage:
//   Slave stream s_*: one packet byte per request. s_tuser marks the first byte of
//   a chunk; with it s_tdata carries the bytes left in the packet.
//   Master stream m_*: exactly one result per input request, in order. m_tuser
//   flags a payload byte, m_tlast ends a chunk (good or bad) with a status,
//   the declared chunk length and, on success, the bytes left after the chunk.
//   Configuration: i_cfg_we writes the output capacity (largest payload accepted);
//   write it only while no request is in flight.
// Pipeline:
//   From input accept to result valid the path is one input register,
//   then the header/payload logic feeding one result register.
//   Throughput is one request per cycle while m_tready does not stall; the
//   per-byte logic is a 16-bit decrement and a few 16-bit compares.
// Reset (i_rst_n low, synchronous): both stages empty, parser idle, capacity 64.
// Stall: when m_tready is low the result register holds, the input register
//   fills, and s_tready drops until the master side drains.
`default_nettype none

module tlv_string_part_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: output capacity register
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    // Slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] bytes_left
    input  wire logic        s_tuser,   // [0] chunk_start
    // Master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] string_byte, [10:8] status,
                                        // [26:11] chunk_length,
                                        // [42:27] remaining_after, [47:43] zero
    output logic             m_tuser,   // [0] byte_valid
    output logic             m_tlast    // chunk_done
);

    localparam int unsigned LW = tlvspp_pkg::LEN_W;
    localparam int unsigned DW = tlvspp_pkg::DATA_W;
    localparam logic [LW-1:0] HDR_LEN = LW'(tlvspp_pkg::HEADER_BYTES);

    // Handshake
    logic s_acc;
    logic adv;

    // Capacity register
    logic [LW-1:0] r_cap;

    // Input stage
    logic          r_in_valid;
    logic [DW-1:0] r_in_byte;
    logic          r_in_start;
    logic [LW-1:0] r_in_left;

    // Parser state
    tlvspp_pkg::t_phase r_phase, n_phase;
    logic [1:0]         r_hcnt,  n_hcnt;
    logic [LW-1:0]      r_dlen,  n_dlen;
    logic [LW-1:0]      r_pleft, n_pleft;
    logic [LW-1:0]      r_kleft, n_kleft;

    // Result stage
    logic                  r_out_valid;
    logic [DW-1:0]         r_byte,  n_byte;
    logic                  r_bval,  n_bval;
    logic                  r_done,  n_done;
    tlvspp_pkg::t_status   r_stat,  n_stat;
    logic [LW-1:0]         r_len,   n_len;
    logic [LW-1:0]         r_rem,   n_rem;

    // Helper values
    logic [LW-1:0] len_full;
    logic [LW-1:0] pl_dec;
    logic [1:0]    hcnt_inc;

    assign adv      = !r_out_valid || m_tready;
    assign s_tready = !r_in_valid || adv;
    assign s_acc    = s_tvalid && s_tready;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= tlvspp_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_byte  <= s_tdata[7:0];
            r_in_left  <= s_tdata[23:8];
            r_in_start <= s_tuser;
        end
    end

    // Parse logic: next state and result for the byte in the input register
    assign len_full = {r_dlen[LW-1:DW], r_in_byte};
    assign pl_dec   = (r_pleft != '0) ? r_pleft - 1'b1 : r_pleft;
    assign hcnt_inc = r_hcnt + 2'd1;

    always_comb begin
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_dlen  = r_dlen;
        n_pleft = r_pleft;
        n_kleft = r_kleft;
        n_byte  = '0;
        n_bval  = 1'b0;
        n_done  = 1'b0;
        n_stat  = tlvspp_pkg::ST_OK;
        n_len   = '0;
        n_rem   = '0;

        if (r_in_start) begin
            // Chunk start: latch bytes left, restart header count
            n_kleft = r_in_left;
            n_dlen  = '0;
            n_pleft = '0;
            if (r_in_left < HDR_LEN) begin
                n_hcnt  = 2'd0;
                n_done  = 1'b1;
                n_stat  = tlvspp_pkg::ST_BUF_SHORT;
                n_phase = tlvspp_pkg::PH_IDLE;
            end else begin
                n_hcnt  = 2'd1;
                n_phase = tlvspp_pkg::PH_HEADER;
            end
        end else begin
            unique case (r_phase)
                tlvspp_pkg::PH_HEADER: begin
                    n_hcnt = hcnt_inc;
                    if (r_hcnt == tlvspp_pkg::HC_LEN_HI) begin
                        n_dlen = {r_in_byte, {DW{1'b0}}};
                    end else if (r_hcnt == tlvspp_pkg::HC_LEN_LO) begin
                        n_dlen = len_full;
                        // Last header byte: run the checks in priority order
                        n_len = len_full;
                        if (len_full > r_kleft) begin
                            n_done  = 1'b1;
                            n_stat  = tlvspp_pkg::ST_TOO_BIG;
                            n_phase = tlvspp_pkg::PH_IDLE;
                        end else if (len_full <= HDR_LEN) begin
                            n_done  = 1'b1;
                            n_stat  = tlvspp_pkg::ST_HDR_SHORT;
                            n_phase = tlvspp_pkg::PH_IDLE;
                        end else if (len_full - HDR_LEN > r_cap) begin
                            n_done  = 1'b1;
                            n_stat  = tlvspp_pkg::ST_OUT_SMALL;
                            n_phase = tlvspp_pkg::PH_IDLE;
                        end else begin
                            n_len   = '0;
                            n_pleft = len_full - HDR_LEN;
                            n_phase = tlvspp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                tlvspp_pkg::PH_PAYLOAD: begin
                    // Pass the byte through; close the chunk on the last one
                    n_byte  = r_in_byte;
                    n_bval  = 1'b1;
                    n_pleft = pl_dec;
                    if (pl_dec == '0) begin
                        n_done  = 1'b1;
                        n_len   = r_dlen;
                        n_phase = tlvspp_pkg::PH_IDLE;
                        if (r_in_byte != '0) begin
                            n_stat = tlvspp_pkg::ST_NO_NUL;
                        end else begin
                            n_stat = tlvspp_pkg::ST_OK;
                            n_rem  = r_kleft - r_dlen;
                        end
                    end
                end
                default: begin
                    n_phase = tlvspp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Parser state update, once per byte moved to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlvspp_pkg::PH_IDLE;
            r_hcnt  <= 2'd0;
            r_dlen  <= '0;
            r_pleft <= '0;
            r_kleft <= '0;
        end else if (adv && r_in_valid) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_dlen  <= n_dlen;
            r_pleft <= n_pleft;
            r_kleft <= n_kleft;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_byte <= n_byte;
            r_bval <= n_bval;
            r_done <= n_done;
            r_stat <= n_stat;
            r_len  <= n_len;
            r_rem  <= n_rem;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'b0, r_rem, r_len, r_stat, r_byte};
    assign m_tuser  = r_bval;
    assign m_tlast  = r_done;

endmodule

`default_nettype wire

/* src/tlvspp_checker.sv */
// Port-level checker for the TLV string chunk parser, bound to the top level.
`default_nettype none

`include "tlv_string_part_parser_core_assert.svh"

module tlvspp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    logic [2:0]  c_stat;
    logic [15:0] c_len;
    logic [15:0] c_rem;
    logic [7:0]  c_byte;

    assign c_byte = m_tdata[7:0];
    assign c_stat = m_tdata[10:8];
    assign c_len  = m_tdata[26:11];
    assign c_rem  = m_tdata[42:27];

    // A stalled result holds
    `TLVSPP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result changed while stalled")

    // Status, length and remainder are only reported at chunk end
    `TLVSPP_ASSERT_NOW(a_mid_zero, i_clk, i_rst_n, m_tvalid && !m_tlast,
        c_stat == tlvspp_pkg::ST_OK && c_len == 16'd0 && c_rem == 16'd0,
        "report fields set without chunk end")

    // Only defined status codes, and no payload byte without byte flag
    `TLVSPP_ASSERT_NOW(a_stat_range, i_clk, i_rst_n, m_tvalid,
        c_stat <= tlvspp_pkg::ST_NO_NUL && (m_tuser || c_byte == 8'd0),
        "bad status code or stray string byte")

    // Header errors end the chunk without a payload byte and without a remainder
    `TLVSPP_ASSERT_NOW(a_hdr_err, i_clk, i_rst_n,
        m_tvalid && m_tlast && (c_stat == tlvspp_pkg::ST_BUF_SHORT ||
        c_stat == tlvspp_pkg::ST_TOO_BIG || c_stat == tlvspp_pkg::ST_HDR_SHORT ||
        c_stat == tlvspp_pkg::ST_OUT_SMALL),
        !m_tuser && c_rem == 16'd0 &&
        (c_stat != tlvspp_pkg::ST_BUF_SHORT || c_len == 16'd0),
        "header error carries payload or remainder")

endmodule

bind tlv_string_part_parser_core tlvspp_checker u_tlvspp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
